### src/swept_box_pair_collision_scan_unit_assert.svh
// Assertion macros for the swept box pair collision scan unit.
`ifndef SWEPT_BOX_PAIR_COLLISION_SCAN_UNIT_ASSERT_SVH
`define SWEPT_BOX_PAIR_COLLISION_SCAN_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SBPCS_ASSERT_SAME(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sbpcs assertion violated");

// Next-cycle implication, disabled while reset is high.
`define SBPCS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sbpcs assertion violated");

`endif

### src/sbpcs_pkg.sv
// Shared constants, types and control structs of the swept box pair scan.
`default_nettype none

package sbpcs_pkg;

  localparam int MAX_ACTORS = 8;
  localparam int COORD_BITS = 16;
  localparam int WIDTH_BITS = 8;

  localparam int IDX_W     = $clog2(MAX_ACTORS);
  localparam int CNT_W     = $clog2(MAX_ACTORS + 1);
  localparam int OUT_IDX_W = 3;
  localparam int SPAN_W    = COORD_BITS + WIDTH_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_now;
    logic signed [COORD_BITS-1:0] x_before;
    logic signed [COORD_BITS-1:0] y_now;
    logic signed [COORD_BITS-1:0] y_before;
    logic [WIDTH_BITS-1:0]        box_width;
    logic                         is_active;
    logic                         has_box;
  } actor_rec_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load;
    logic             issue;
    logic [IDX_W-1:0] rd_a;
    logic [IDX_W-1:0] rd_b;
    logic             finish;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dp_status_t;

endpackage

`default_nettype wire

### src/sbpcs_datapath.sv
// Datapath: actor record store, pair overlap test, pending pair and result registers.
`default_nettype none

module sbpcs_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire sbpcs_pkg::ctrl_cmd_t                  cmd,
  output sbpcs_pkg::dp_status_t                      status,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] x_now,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] x_before,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] y_now,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] y_before,
  input  wire logic [sbpcs_pkg::WIDTH_BITS-1:0]      box_width,
  input  wire logic                                  is_active,
  input  wire logic                                  has_box,
  output logic                                       strobe,
  output logic [sbpcs_pkg::OUT_IDX_W-1:0]            first_index,
  output logic [sbpcs_pkg::OUT_IDX_W-1:0]            second_index,
  output logic                                       pair_valid,
  output logic                                       dropped_actors,
  output logic                                       last_result
);
  import sbpcs_pkg::*;

  actor_rec_t       store [MAX_ACTORS];
  actor_rec_t       rd_a;
  actor_rec_t       rd_b;
  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             room;
  logic             pipe_valid;
  logic [IDX_W-1:0] pipe_a;
  logic [IDX_W-1:0] pipe_b;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_a;
  logic [IDX_W-1:0] pend_b;
  logic             hit;

  logic signed [COORD_BITS-1:0] ax_lo, ax_hi, bx_lo, bx_hi;
  logic signed [COORD_BITS-1:0] ay_lo, ay_hi, by_lo, by_hi;
  logic signed [SPAN_W-1:0]     axl, axh, bxl, bxh;

  assign room         = (count != CNT_W'(MAX_ACTORS));
  assign status.count = count;

  // Record store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      store[count[IDX_W-1:0]] <= '{x_now: x_now, x_before: x_before, y_now: y_now,
                                   y_before: y_before, box_width: box_width,
                                   is_active: is_active, has_box: has_box};
    end
    if (cmd.issue) begin
      rd_a <= store[cmd.rd_a];
      rd_b <= store[cmd.rd_b];
    end
  end

  always_comb begin
    ax_lo = (rd_a.x_now < rd_a.x_before) ? rd_a.x_now : rd_a.x_before;
    ax_hi = (rd_a.x_now < rd_a.x_before) ? rd_a.x_before : rd_a.x_now;
    bx_lo = (rd_b.x_now < rd_b.x_before) ? rd_b.x_now : rd_b.x_before;
    bx_hi = (rd_b.x_now < rd_b.x_before) ? rd_b.x_before : rd_b.x_now;
    ay_lo = (rd_a.y_now < rd_a.y_before) ? rd_a.y_now : rd_a.y_before;
    ay_hi = (rd_a.y_now < rd_a.y_before) ? rd_a.y_before : rd_a.y_now;
    by_lo = (rd_b.y_now < rd_b.y_before) ? rd_b.y_now : rd_b.y_before;
    by_hi = (rd_b.y_now < rd_b.y_before) ? rd_b.y_before : rd_b.y_now;
    // Swept x span ends at max x plus width minus one, formed wide.
    axl = SPAN_W'(ax_lo);
    bxl = SPAN_W'(bx_lo);
    axh = SPAN_W'(ax_hi) + SPAN_W'($signed({1'b0, rd_a.box_width})) - SPAN_W'(1);
    bxh = SPAN_W'(bx_hi) + SPAN_W'($signed({1'b0, rd_b.box_width})) - SPAN_W'(1);
    hit = rd_a.is_active && rd_a.has_box && rd_b.is_active && rd_b.has_box &&
          !(bxl > axh || bxh < axl) && !(by_lo > ay_hi || by_hi < ay_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflow   <= 1'b0;
      pipe_valid <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      pipe_valid <= cmd.issue;
      pipe_a     <= cmd.rd_a;
      pipe_b     <= cmd.rd_b;
      if (cmd.load) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      // Hold one hit back so the frame's final result can be marked.
      if (pipe_valid && hit) begin
        if (pend_valid) begin
          strobe         <= 1'b1;
          first_index    <= OUT_IDX_W'(pend_a);
          second_index   <= OUT_IDX_W'(pend_b);
          pair_valid     <= 1'b1;
          dropped_actors <= 1'b0;
          last_result    <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_a     <= pipe_a;
        pend_b     <= pipe_b;
      end
      if (cmd.finish) begin
        strobe         <= 1'b1;
        first_index    <= pend_valid ? OUT_IDX_W'(pend_a) : '0;
        second_index   <= pend_valid ? OUT_IDX_W'(pend_b) : '0;
        pair_valid     <= pend_valid;
        dropped_actors <= overflow;
        last_result    <= 1'b1;
        pend_valid     <= 1'b0;
        count          <= '0;
        overflow       <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/sbpcs_controller.sv
// Controller: load acceptance and pair enumeration state machine.
`default_nettype none

module sbpcs_controller (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic                    last_actor,
  input  wire sbpcs_pkg::dp_status_t   status,
  output sbpcs_pkg::ctrl_cmd_t         cmd,
  output logic                         busy
);
  import sbpcs_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] i_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
  end

  assign j_inc  = CNT_W'(j) + CNT_W'(1);
  assign i_skip = CNT_W'(i) + CNT_W'(2);
  assign busy   = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = start;
        if (start && last_actor) begin
          state_next = ST_SCAN;
          i_next     = '0;
          j_next     = IDX_W'(1);
        end
      end
      ST_SCAN: begin
        if (CNT_W'(j) < status.count) begin
          cmd.issue = 1'b1;
          cmd.rd_a  = i;
          cmd.rd_b  = j;
          // Advance along the row, then to the next row's first partner.
          if (j_inc < status.count) begin
            j_next = j_inc[IDX_W-1:0];
          end else if (i_skip < status.count) begin
            i_next = i + IDX_W'(1);
            j_next = i_skip[IDX_W-1:0];
          end else begin
            state_next = ST_DRAIN;
          end
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/swept_box_pair_collision_scan_unit.sv
// Top level of the swept box pair collision scan unit.
//
// Usage: present one actor record with start high; it is taken at an edge
// where busy is low. Each non-final record is written to the store and busy stays
// low. A record with last_actor high starts the scan of all pairs i<j over
// the records stored this frame (up to MAX_ACTORS; later ones are dropped).
// The scan reads one pair per cycle from the record store, and busy stays high
// through the scan and the drain and finish states that follow it.
// Results: each colliding pair appears on the result ports for one cycle with
// strobe high; the last result of the frame carries last_result and the
// dropped flag, and is on the ports in the first cycle that busy is low. A
// frame with no hits gives one result with pair_valid low. The receiver cannot
// stall: results must be taken as they appear.
// Reset: synchronous, active high; clears the load count, the dropped flag and
// the control state. The record store itself is not cleared.
`default_nettype none

`include "swept_box_pair_collision_scan_unit_assert.svh"

module swept_box_pair_collision_scan_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] x_now,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] x_before,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] y_now,
  input  wire logic signed [sbpcs_pkg::COORD_BITS-1:0] y_before,
  input  wire logic [sbpcs_pkg::WIDTH_BITS-1:0]        box_width,
  input  wire logic                                    is_active,
  input  wire logic                                    has_box,
  input  wire logic                                    last_actor,
  output logic                                         strobe,
  output logic [sbpcs_pkg::OUT_IDX_W-1:0]              first_index,
  output logic [sbpcs_pkg::OUT_IDX_W-1:0]              second_index,
  output logic                                         pair_valid,
  output logic                                         dropped_actors,
  output logic                                         last_result
);
  import sbpcs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sbpcs_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_actor (last_actor),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  sbpcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .x_now          (x_now),
    .x_before       (x_before),
    .y_now          (y_now),
    .y_before       (y_before),
    .box_width      (box_width),
    .is_active      (is_active),
    .has_box        (has_box),
    .strobe         (strobe),
    .first_index    (first_index),
    .second_index   (second_index),
    .pair_valid     (pair_valid),
    .dropped_actors (dropped_actors),
    .last_result    (last_result)
  );

  `SBPCS_ASSERT_SAME(a_empty_is_final, clk, rst, strobe && !pair_valid, last_result)
  `SBPCS_ASSERT_SAME(a_drop_only_final, clk, rst, strobe && !last_result, !dropped_actors)
  `SBPCS_ASSERT_SAME(a_pair_ordered, clk, rst, strobe && pair_valid, first_index < second_index)
  `SBPCS_ASSERT_SAME(a_final_after_scan, clk, rst, strobe && last_result, !busy)
  `SBPCS_ASSERT_NEXT(a_scan_starts, clk, rst, start && !busy && last_actor, busy)

endmodule

`default_nettype wire
